### hdl/kmst_pkg.sv
// shared types and constants for the kruskal mst cost unit
package kmst_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;
    localparam int COST_BITS    = 16;
    localparam int VIDX_BITS    = $clog2(MAX_VERTICES);
    localparam int EIDX_BITS    = $clog2(MAX_EDGES);
    localparam int ECNT_BITS    = EIDX_BITS + 1;
    localparam int VCNT_BITS    = 7;
    localparam int TOTAL_BITS   = 22;
    localparam int USED_BITS    = 6;

    typedef struct packed {
        logic [6:0]  edge_from;
        logic [6:0]  edge_to;
        logic [15:0] edge_cost;
        logic        edge_present;
        logic        last_edge;
    } in_t;

    typedef struct packed {
        logic [21:0] total_cost;
        logic [5:0]  edges_used;
        logic        spanning;
        logic        store_overflow;
        logic        bad_vertex_seen;
    } out_t;

    typedef struct packed {
        logic [VIDX_BITS-1:0] a;
        logic [VIDX_BITS-1:0] b;
        logic [COST_BITS-1:0] cost;
    } edge_t;

    typedef struct packed {
        logic load;
        logic start;
        logic init_wr;
        logic pass_start;
        logic scan_rd;
        logic scan_cmp;
        logic pick_rd;
        logic get;
        logic walk_rd;
        logic fa_step;
        logic fb_step;
        logic unite;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic init_last;
        logic no_more;
        logic scan_last;
        logic found;
        logic bad_edge;
        logic at_root;
        logic out_busy;
    } status_t;

endpackage

### hdl/kmst_ctrl.sv
// sequencer for loading, edge selection and union-find steps
module kmst_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_last,
    output logic             in_ready,
    input  kmst_pkg::status_t sts,
    output kmst_pkg::cmd_t    cmd
);
    import kmst_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_PASS, S_SCAN_RD, S_SCAN_CMP, S_PICK, S_GET,
        S_FA_RD, S_FA_CHK, S_FB_RD, S_FB_CHK, S_UNITE, S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load  = 1'b1;
                    cmd.start = in_last;
                    if (in_last)
                        state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (sts.init_last)
                    state_next = S_PASS;
            end
            S_PASS:
            begin
                cmd.pass_start = 1'b1;
                state_next = sts.no_more ? S_DONE : S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                cmd.scan_cmp = 1'b1;
                state_next   = sts.scan_last ? S_PICK : S_SCAN_RD;
            end
            S_PICK:
            begin
                cmd.pick_rd = 1'b1;
                state_next  = sts.found ? S_GET : S_DONE;
            end
            S_GET:
            begin
                cmd.get    = 1'b1;
                state_next = sts.bad_edge ? S_PASS : S_FA_RD;
            end
            S_FA_RD:
            begin
                cmd.walk_rd = 1'b1;
                state_next  = S_FA_CHK;
            end
            S_FA_CHK:
            begin
                cmd.fa_step = 1'b1;
                state_next  = sts.at_root ? S_FB_RD : S_FA_RD;
            end
            S_FB_RD:
            begin
                cmd.walk_rd = 1'b1;
                state_next  = S_FB_CHK;
            end
            S_FB_CHK:
            begin
                cmd.fb_step = 1'b1;
                state_next  = sts.at_root ? S_UNITE : S_FB_RD;
            end
            S_UNITE:
            begin
                cmd.unite  = 1'b1;
                state_next = S_PASS;
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### hdl/kmst_datapath.sv
// edge store, parent store, selection scan and cost accumulation
module kmst_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [6:0]          cfg_wr_data,
    input  kmst_pkg::in_t       in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output kmst_pkg::out_t      out_data,
    input  kmst_pkg::cmd_t      cmd,
    output kmst_pkg::status_t   sts
);
    import kmst_pkg::*;

    edge_t                 edge_mem [MAX_EDGES];
    logic [VIDX_BITS-1:0]  parent_mem [MAX_VERTICES];

    logic [VCNT_BITS-1:0]  vcount_reg;
    logic [ECNT_BITS-1:0]  edge_cnt_reg;
    logic                  ovf_reg;
    logic                  bad_reg;
    logic                  out_valid_reg;
    out_t                  out_reg;

    edge_t                 edge_rd_reg;
    logic [VIDX_BITS-1:0]  parent_rd_reg;
    logic [VIDX_BITS-1:0]  init_idx_reg;
    logic [EIDX_BITS-1:0]  scan_idx_reg;
    logic                  found_reg;
    logic [EIDX_BITS-1:0]  best_idx_reg;
    logic [COST_BITS-1:0]  best_cost_reg;
    logic                  prev_valid_reg;
    logic [EIDX_BITS-1:0]  prev_idx_reg;
    logic [COST_BITS-1:0]  prev_cost_reg;
    logic [VIDX_BITS-1:0]  node_reg;
    logic [VIDX_BITS-1:0]  cur_b_reg;
    logic [VIDX_BITS-1:0]  root_a_reg;
    logic [VIDX_BITS-1:0]  root_b_reg;
    logic [TOTAL_BITS-1:0] total_reg;
    logic [USED_BITS-1:0]  used_reg;

    logic [VCNT_BITS-1:0]  nv;
    logic                  in_ok;
    logic                  cand;
    logic [TOTAL_BITS:0]   sum;
    logic [VCNT_BITS-1:0]  used_p1;

    // zero acts as one, anything above the maximum acts as the maximum
    always_comb
    begin
        if (vcount_reg == '0)
            nv = VCNT_BITS'(1);
        else if (vcount_reg > VCNT_BITS'(MAX_VERTICES))
            nv = VCNT_BITS'(MAX_VERTICES);
        else
            nv = vcount_reg;
    end

    assign in_ok = (in_data.edge_from != '0) && (in_data.edge_from <= nv)
                && (in_data.edge_to != '0) && (in_data.edge_to <= nv);

    // next in (cost, index) order after the last edge handled
    assign cand = (!prev_valid_reg || (edge_rd_reg.cost > prev_cost_reg)
                   || ((edge_rd_reg.cost == prev_cost_reg) && (scan_idx_reg > prev_idx_reg)))
                  && (!found_reg || (edge_rd_reg.cost < best_cost_reg));

    assign sum     = {1'b0, total_reg} + (TOTAL_BITS+1)'(edge_rd_reg.cost);
    assign used_p1 = VCNT_BITS'(used_reg) + VCNT_BITS'(1);

    always_comb
    begin
        sts.init_last = (init_idx_reg == VIDX_BITS'(MAX_VERTICES - 1));
        sts.no_more   = (edge_cnt_reg == '0) || (used_p1 >= nv);
        sts.scan_last = (ECNT_BITS'(scan_idx_reg) + ECNT_BITS'(1) == edge_cnt_reg);
        sts.found     = found_reg;
        sts.bad_edge  = (VCNT_BITS'(edge_rd_reg.a) >= nv) || (VCNT_BITS'(edge_rd_reg.b) >= nv);
        sts.at_root   = (parent_rd_reg == node_reg);
        sts.out_busy  = out_valid_reg;
    end

    // edge store
    always_ff @(posedge clk)
    begin
        if (cmd.load && in_data.edge_present && in_ok
            && (edge_cnt_reg != ECNT_BITS'(MAX_EDGES)))
            edge_mem[edge_cnt_reg[EIDX_BITS-1:0]] <= '{a: VIDX_BITS'(in_data.edge_from - 7'd1),
                                                      b: VIDX_BITS'(in_data.edge_to - 7'd1),
                                                      cost: in_data.edge_cost[COST_BITS-1:0]};
        if (cmd.scan_rd || cmd.pick_rd)
            edge_rd_reg <= edge_mem[cmd.pick_rd ? best_idx_reg : scan_idx_reg];
    end

    // parent store
    always_ff @(posedge clk)
    begin
        if (cmd.init_wr)
            parent_mem[init_idx_reg] <= init_idx_reg;
        else if (cmd.unite && (root_a_reg != root_b_reg))
            parent_mem[root_a_reg] <= root_b_reg;
        if (cmd.walk_rd)
            parent_rd_reg <= parent_mem[node_reg];
    end

    // working registers of one computation
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            init_idx_reg   <= '0;
            prev_valid_reg <= 1'b0;
            total_reg      <= '0;
            used_reg       <= '0;
        end
        if (cmd.init_wr)
            init_idx_reg <= init_idx_reg + VIDX_BITS'(1);
        if (cmd.pass_start)
        begin
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
        end
        if (cmd.scan_cmp)
        begin
            if (cand)
            begin
                found_reg     <= 1'b1;
                best_idx_reg  <= scan_idx_reg;
                best_cost_reg <= edge_rd_reg.cost;
            end
            scan_idx_reg <= scan_idx_reg + EIDX_BITS'(1);
        end
        if (cmd.get)
        begin
            prev_valid_reg <= 1'b1;
            prev_idx_reg   <= best_idx_reg;
            prev_cost_reg  <= best_cost_reg;
            node_reg       <= edge_rd_reg.a;
            cur_b_reg      <= edge_rd_reg.b;
        end
        if (cmd.fa_step)
        begin
            if (parent_rd_reg == node_reg)
            begin
                root_a_reg <= node_reg;
                node_reg   <= cur_b_reg;
            end
            else
                node_reg <= parent_rd_reg;
        end
        if (cmd.fb_step)
        begin
            if (parent_rd_reg == node_reg)
                root_b_reg <= node_reg;
            else
                node_reg <= parent_rd_reg;
        end
        if (cmd.unite && (root_a_reg != root_b_reg))
        begin
            total_reg <= sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
            used_reg  <= used_reg + USED_BITS'(1);
        end
        if (cmd.finish)
        begin
            out_reg.total_cost      <= total_reg;
            out_reg.edges_used      <= used_reg;
            out_reg.spanning        <= (used_p1 == nv);
            out_reg.store_overflow  <= ovf_reg;
            out_reg.bad_vertex_seen <= bad_reg;
        end
    end

    // control and flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= VCNT_BITS'(MAX_VERTICES);
            edge_cnt_reg  <= '0;
            ovf_reg       <= 1'b0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                vcount_reg <= cfg_wr_data;
            if (cmd.load && in_data.edge_present)
            begin
                if (!in_ok)
                    bad_reg <= 1'b1;
                else if (edge_cnt_reg == ECNT_BITS'(MAX_EDGES))
                    ovf_reg <= 1'b1;
                else
                    edge_cnt_reg <= edge_cnt_reg + ECNT_BITS'(1);
            end
            if (cmd.get && sts.bad_edge)
                bad_reg <= 1'b1;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                edge_cnt_reg  <= '0;
                ovf_reg       <= 1'b0;
                bad_reg       <= 1'b0;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### hdl/kruskal_mst_cost_unit.sv
// Kruskal minimum spanning tree cost unit. Edges load at one transaction per cycle into a
// 256-entry edge store; the transaction marked last_edge starts the computation and in_ready
// stays low until it ends. The computation first sets up all 64 entries of the parent store.
// After that, each edge it handles (taken, rejected or out of range) goes through a selection
// scan over the E stored edges, a pick and a fetch. An edge that is in range then adds two
// root walks, with a read and a check per node visited, and a join. Once the tree is complete
// the search ends at the start of the next pass; when no edge is left, a last scan that finds
// no candidate ends it. The selection scans, which read the single-port edge store one entry
// at a time, make up most of the work. The result sits in an output register until taken,
// and loading of the next graph may start while it waits.
module kruskal_mst_cost_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic [6:0]      cfg_wr_data,
    input  logic            in_valid,
    output logic            in_ready,
    input  kmst_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output kmst_pkg::out_t  out_data
);
    import kmst_pkg::*;

    cmd_t    cmd;
    status_t sts;

    kmst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (in_data.last_edge),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    kmst_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

### hdl/kmst_checker.sv
// port-level checks for the kruskal mst cost unit
module kmst_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input kmst_pkg::in_t   in_data,
    input logic            out_valid,
    input logic            out_ready,
    input kmst_pkg::out_t  out_data
);
    import kmst_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.last_edge |=> !in_ready)
        else $error("input taken during computation");

    a_cost_needs_edges: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.total_cost == '0) || (out_data.edges_used != '0))
        else $error("nonzero cost with no edges");

endmodule

bind kruskal_mst_cost_unit kmst_checker u_kmst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
